FILE: design/kebd_pkg.sv
// Shared types and constants for the key event block decoder.
`default_nettype none
package kebd_pkg;

  localparam int MAX_EVENTS_DEF = 8;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT = 3'd4;
  localparam int CFG_DATA_W = 8;

  // key codes and block constants
  localparam logic [7:0] DEPTH_MASK  = 8'h3f;
  localparam logic [7:0] CODE_ESC    = 8'hb1;
  localparam logic [7:0] CODE_LEFT   = 8'hb4;
  localparam logic [7:0] CODE_UP     = 8'hb5;
  localparam logic [7:0] CODE_DOWN   = 8'hb6;
  localparam logic [7:0] CODE_RIGHT  = 8'hb7;
  localparam logic [7:0] CODE_MOD_LO = 8'ha1;
  localparam logic [7:0] CODE_CTRL   = 8'ha5;
  localparam logic [7:0] ESC_CHAR    = 8'h1b;
  localparam logic [7:0] STATE_IDLE  = 8'h00;
  localparam logic [7:0] STATE_REL   = 8'h03;

  localparam logic RESULT_KEY     = 1'b0;
  localparam logic RESULT_SUMMARY = 1'b1;

  // result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic [7:0] block_byte;
    logic       block_start;
    logic       line_level;
  } in_word_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] key_value;
    logic [1:0] event_type;
    logic       more_pending;
    logic       last_result;
  } out_word_t;

endpackage
`default_nettype wire

FILE: design/key_event_block_decoder.sv
// Top level: byte-serial key status block decoder with result queue.
`default_nettype none
// Takes one block byte per cycle while in_ready is high.
// A block is 4 + 2*MAX_EVENTS bytes; its last byte yields a summary word,
// and may also yield a key word, so that byte puts up to two queue words.
// Decoding is a single pass of compares per byte; results go to a 4-entry
// queue and in_ready is high while at least two entries are free, so with
// out_ready held high the block sustains one byte per cycle. Config writes
// take effect the next cycle and must be done while the block is idle.
module key_event_block_decoder #(
  parameter int MAX_EVENTS = kebd_pkg::MAX_EVENTS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire kebd_pkg::in_word_t           in_data,
  output logic                              out_valid,
  input  wire                               out_ready,
  output kebd_pkg::out_word_t               out_data,
  input  wire                               cfg_we,
  input  wire [kebd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [kebd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int BLOCK_LEN = 4 + 2 * MAX_EVENTS;
  localparam int POS_W     = $clog2(BLOCK_LEN + 1);
  localparam int CNT_W     = $clog2(MAX_EVENTS + 1);

  // config registers
  logic       attn_r;
  logic [7:0] kc_up_r, kc_down_r, kc_left_r, kc_right_r;

  // parse state
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [5:0]       qdepth_r, qdepth_nxt;
  logic [CNT_W-1:0] evcnt_r, evcnt_nxt;
  logic             stopped_r, stopped_nxt;
  logic [7:0]       held_r, held_nxt;
  logic             ctrl_r, ctrl_nxt;

  // result queue
  kebd_pkg::out_word_t          q_r [kebd_pkg::QDEPTH];
  logic [kebd_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [kebd_pkg::QCNT_W-1:0]  cnt_r;

  logic             in_acc, out_acc;
  logic [7:0]       b;
  logic [POS_W-1:0] pos_eff, idx;
  logic             stopped_eff;
  logic [7:0]       held_eff;
  logic             active, in_pairs, is_last;
  logic             is_mod, ev_push, sum_push;
  logic [7:0]       key_val;
  logic             special;
  logic             more;
  kebd_pkg::out_word_t ev_word, sum_word;
  logic [1:0]       n_push;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign b       = in_data.block_byte;

  always_comb begin
    pos_eff     = in_data.block_start ? '0 : pos_r;
    stopped_eff = in_data.block_start ? 1'b0 : stopped_r;
    held_eff    = in_data.block_start ? 8'h00 : held_r;
    active      = pos_eff < POS_W'(BLOCK_LEN);
    is_last     = pos_eff == POS_W'(BLOCK_LEN - 1);
    idx         = (pos_eff - POS_W'(4)) >> 1;
    in_pairs    = (pos_eff >= POS_W'(4)) && (idx < POS_W'(evcnt_r)) && !stopped_eff;
    is_mod      = (b >= kebd_pkg::CODE_MOD_LO) && (b <= kebd_pkg::CODE_CTRL);

    special = 1'b1;
    case (b)
      kebd_pkg::CODE_UP:    key_val = kc_up_r;
      kebd_pkg::CODE_DOWN:  key_val = kc_down_r;
      kebd_pkg::CODE_LEFT:  key_val = kc_left_r;
      kebd_pkg::CODE_RIGHT: key_val = kc_right_r;
      default: begin
        special = 1'b0;
        if (b == kebd_pkg::CODE_ESC) key_val = kebd_pkg::ESC_CHAR;
        // ctrl folds letters of either case to 1..26
        else if (ctrl_r && ((b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a)))
          key_val = {3'b000, b[4:0]};
        else key_val = b;
      end
    endcase

    ev_push  = active && in_pairs && pos_eff[0] && !is_mod;
    sum_push = active && is_last;
    more     = (8'(qdepth_r) > 8'(evcnt_r)) || (attn_r && in_data.line_level);

    ev_word.result_kind  = kebd_pkg::RESULT_KEY;
    ev_word.key_value    = key_val;
    ev_word.event_type   = {special, held_eff == kebd_pkg::STATE_REL};
    ev_word.more_pending = 1'b0;
    ev_word.last_result  = !sum_push;

    sum_word.result_kind  = kebd_pkg::RESULT_SUMMARY;
    sum_word.key_value    = 8'h00;
    sum_word.event_type   = 2'b00;
    sum_word.more_pending = more;
    sum_word.last_result  = 1'b1;

    n_push = {1'b0, ev_push} + {1'b0, sum_push};

    pos_nxt     = pos_r;
    qdepth_nxt  = qdepth_r;
    evcnt_nxt   = evcnt_r;
    stopped_nxt = stopped_r;
    held_nxt    = held_r;
    ctrl_nxt    = ctrl_r;
    if (active) begin
      pos_nxt     = pos_eff + POS_W'(1);
      stopped_nxt = stopped_eff;
      held_nxt    = held_eff;
      if (pos_eff == '0) begin
        qdepth_nxt  = b[5:0] & kebd_pkg::DEPTH_MASK[5:0];
        evcnt_nxt   = '0;
        stopped_nxt = 1'b0;
        held_nxt    = 8'h00;
      end else if (pos_eff == POS_W'(3)) begin
        evcnt_nxt = (b > 8'(MAX_EVENTS)) ? CNT_W'(MAX_EVENTS) : CNT_W'(b);
      end else if (in_pairs) begin
        if (!pos_eff[0]) begin
          if (b == kebd_pkg::STATE_IDLE) stopped_nxt = 1'b1;
          else held_nxt = b;
        end else if (b == kebd_pkg::CODE_CTRL) begin
          ctrl_nxt = held_eff != kebd_pkg::STATE_REL;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attn_r     <= 1'b0;
      kc_up_r    <= 8'd1;
      kc_down_r  <= 8'd2;
      kc_left_r  <= 8'd3;
      kc_right_r <= 8'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        kebd_pkg::CFG_ATTN:  attn_r     <= cfg_data[0];
        kebd_pkg::CFG_UP:    kc_up_r    <= cfg_data;
        kebd_pkg::CFG_DOWN:  kc_down_r  <= cfg_data;
        kebd_pkg::CFG_LEFT:  kc_left_r  <= cfg_data;
        kebd_pkg::CFG_RIGHT: kc_right_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      qdepth_r  <= '0;
      evcnt_r   <= '0;
      stopped_r <= 1'b0;
      held_r    <= 8'h00;
      ctrl_r    <= 1'b0;
    end else if (in_acc) begin
      pos_r     <= pos_nxt;
      qdepth_r  <= qdepth_nxt;
      evcnt_r   <= evcnt_nxt;
      stopped_r <= stopped_nxt;
      held_r    <= held_nxt;
      ctrl_r    <= ctrl_nxt;
    end
  end

  // queue payload: key word first, summary behind it
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (ev_push) q_r[wr_ptr_r] <= ev_word;
      if (sum_push) begin
        if (ev_push) q_r[kebd_pkg::QPTR_W'(wr_ptr_r + 1'b1)] <= sum_word;
        else q_r[wr_ptr_r] <= sum_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_acc) wr_ptr_r <= wr_ptr_r + kebd_pkg::QPTR_W'(n_push);
      if (out_acc) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + (in_acc ? kebd_pkg::QCNT_W'(n_push) : '0)
                     - kebd_pkg::QCNT_W'(out_acc);
    end
  end

  assign in_ready  = cnt_r <= kebd_pkg::QCNT_W'(kebd_pkg::QDEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign out_data  = q_r[rd_ptr_r];

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= kebd_pkg::QCNT_W'(kebd_pkg::QDEPTH))
    else $error("result queue overflow");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(BLOCK_LEN))
    else $error("byte position past block end");

  a_start_pos: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.block_start |=> pos_r == POS_W'(1))
    else $error("block start did not restart position");

  a_sum_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == kebd_pkg::RESULT_SUMMARY |-> out_data.last_result)
    else $error("summary word not marked last");
`endif

endmodule
`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the key event block decoder: directed rows plus random blocks.
`timescale 1ns / 1ps
module testbench;
  import kebd_pkg::*;

  localparam int BLOCK_BYTES = 4 + 2 * MAX_EVENTS_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int RAND_ITEMS = 1400;
  localparam int PHASES = 6;

  localparam logic [1:0] EV_PRESS           = 2'd0;
  localparam logic [1:0] EV_RELEASE         = 2'd1;
  localparam logic [1:0] EV_SPECIAL_PRESS   = 2'd2;
  localparam logic [1:0] EV_SPECIAL_RELEASE = 2'd3;

  localparam logic [7:0] CHAR_LO_A = 8'h61;
  localparam logic [7:0] CHAR_LO_Z = 8'h7a;
  localparam logic [7:0] CHAR_UP_A = 8'h41;
  localparam logic [7:0] CHAR_UP_Z = 8'h5a;

  typedef struct packed {
    in_word_t  w;
    logic      typed;
    out_word_t want;
  } step_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_word_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_word_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // decoder model state
  logic [4:0] pos_q;
  logic [5:0] depth_q;
  logic [3:0] count_q;
  logic       stopped_q;
  logic [7:0] state_q;
  logic       ctrl_q;
  logic       attn_r;
  logic [7:0] up_r, down_r, left_r, right_r;

  out_word_t awaited_words[$];
  step_row_t steps[$];
  int        fail_count;
  int        items_taken;
  int        key_seen;
  int        summary_seen;
  bit        steady;

  key_event_block_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic out_word_t key_word(input logic [7:0] v, input logic [1:0] et);
    out_word_t k;
    k = '0;
    k.result_kind = RESULT_KEY;
    k.key_value = v;
    k.event_type = et;
    k.last_result = 1'b1;
    return k;
  endfunction

  // a typed word always has last_result set, so an all-zero word means "use the model"
  function automatic step_row_t mk_row(input logic [7:0] b, input logic s,
                                       input out_word_t want);
    step_row_t row;
    row.w.block_byte = b;
    row.w.block_start = s;
    row.w.line_level = 1'($urandom_range(0, 1));
    row.typed = (want != '0);
    row.want = want;
    return row;
  endfunction

  task automatic decode_byte(input in_word_t w, output bit taken);
    logic [4:0] at;
    logic [7:0] b;
    logic       special;
    logic       rel;
    out_word_t  r;
    out_word_t  got[$];
    b = w.block_byte;
    if (w.block_start) begin
      pos_q = '0;
      stopped_q = 1'b0;
      state_q = STATE_IDLE;
    end
    taken = (pos_q < BLOCK_BYTES);
    if (!taken) return;
    at = pos_q;
    if (at == 5'd0) begin
      depth_q = 6'(b & DEPTH_MASK);
      count_q = '0;
      stopped_q = 1'b0;
      state_q = STATE_IDLE;
    end else if (at == 5'd3) begin
      count_q = (b > 8'(MAX_EVENTS_DEF)) ? 4'(MAX_EVENTS_DEF) : b[3:0];
    end else if (at >= 5'd4 && ((at - 5'd4) >> 1) < 5'(count_q) && !stopped_q) begin
      if (!at[0]) begin
        if (b == STATE_IDLE) stopped_q = 1'b1;
        else state_q = b;
      end else if (b >= CODE_MOD_LO && b <= CODE_CTRL) begin
        // modifiers give no word; Ctrl latches unless its state is release
        if (b == CODE_CTRL) ctrl_q = (state_q != STATE_REL);
      end else begin
        r = '0;
        r.result_kind = RESULT_KEY;
        special = 1'b1;
        case (b)
          CODE_UP:    r.key_value = up_r;
          CODE_DOWN:  r.key_value = down_r;
          CODE_LEFT:  r.key_value = left_r;
          CODE_RIGHT: r.key_value = right_r;
          default: begin
            special = 1'b0;
            if (b == CODE_ESC) r.key_value = ESC_CHAR;
            else if (ctrl_q && b >= CHAR_LO_A && b <= CHAR_LO_Z)
              r.key_value = b - CHAR_LO_A + 8'd1;
            else if (ctrl_q && b >= CHAR_UP_A && b <= CHAR_UP_Z)
              r.key_value = b - CHAR_UP_A + 8'd1;
            else r.key_value = b;
          end
        endcase
        rel = (state_q == STATE_REL);
        if (special) r.event_type = rel ? EV_SPECIAL_RELEASE : EV_SPECIAL_PRESS;
        else r.event_type = rel ? EV_RELEASE : EV_PRESS;
        got.push_back(r);
      end
    end
    if (at == BLOCK_BYTES - 1) begin
      r = '0;
      r.result_kind = RESULT_SUMMARY;
      r.more_pending = (depth_q > 6'(count_q)) || (attn_r && w.line_level);
      got.push_back(r);
    end
    if (got.size() != 0) begin
      r = got.pop_back();
      r.last_result = 1'b1;
      got.push_back(r);
    end
    foreach (got[i]) awaited_words.push_back(got[i]);
    pos_q = at + 5'd1;
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic put_word(input in_word_t w, input bit typed, input out_word_t want);
    int gap;
    int mark;
    bit taken;
    gap = steady ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    mark = awaited_words.size();
    decode_byte(w, taken);
    if (typed) begin
      while (awaited_words.size() > mark) void'(awaited_words.pop_back());
      awaited_words.push_back(want);
    end
    if (taken) items_taken++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // writes all five registers plus one unused index; cfg_we drops after the last
  task automatic load_settings(input logic [4:0][7:0] vals);
    logic [CFG_IDX_W-1:0] idx;
    logic [7:0]           data;
    for (int i = 0; i < 6; i++) begin
      if (i < 5) begin
        idx = CFG_ATTN + CFG_IDX_W'(i);
        data = vals[i];
      end else begin
        idx = CFG_IDX_W'($urandom_range(int'(CFG_RIGHT) + 1, (1 << CFG_IDX_W) - 1));
        data = 8'($urandom);
      end
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_data <= data;
      @(posedge clk);
      case (idx)
        CFG_ATTN:  attn_r = data[0];
        CFG_UP:    up_r = data;
        CFG_DOWN:  down_r = data;
        CFG_LEFT:  left_r = data;
        CFG_RIGHT: right_r = data;
        default: ;
      endcase
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_block();
    logic [7:0] bytes [BLOCK_BYTES];
    logic [7:0] code;
    logic [7:0] st;
    int         r;
    int         rc;
    int         n_ev;
    int         stop_at;
    r = $urandom_range(0, 99);
    steady = ($urandom_range(0, 4) == 0);
    if (r < 5) begin
      // noise: random bytes with a stray block start here and there
      for (int i = 0; i < BLOCK_BYTES; i++)
        put_word({8'($urandom), (i == 0) || ($urandom_range(0, 15) == 0),
                  1'($urandom_range(0, 1))}, 1'b0, '0);
      return;
    end
    if ($urandom_range(0, 1) == 1)
      bytes[0] = {2'($urandom_range(0, 3)), 6'($urandom_range(0, 10))};
    else
      bytes[0] = 8'($urandom);
    bytes[1] = 8'($urandom);
    bytes[2] = 8'($urandom);
    if ($urandom_range(0, 19) < 16) bytes[3] = 8'($urandom_range(0, MAX_EVENTS_DEF));
    else bytes[3] = 8'($urandom_range(MAX_EVENTS_DEF + 1, 255));
    n_ev = (bytes[3] > 8'(MAX_EVENTS_DEF)) ? MAX_EVENTS_DEF : int'(bytes[3]);
    for (int k = 0; k < MAX_EVENTS_DEF; k++) begin
      rc = $urandom_range(0, 99);
      if (rc < 45) st = 8'd1;
      else if (rc < 70) st = STATE_REL;
      else if (rc < 80) st = 8'd2;
      else if (rc < 92) st = 8'($urandom_range(1, 255));
      else st = STATE_IDLE;
      rc = $urandom_range(0, 99);
      if (rc < 25) code = 8'($urandom_range(CHAR_LO_A, CHAR_LO_Z));
      else if (rc < 40) code = 8'($urandom_range(CHAR_UP_A, CHAR_UP_Z));
      else if (rc < 55) code = 8'($urandom_range(CODE_LEFT, CODE_RIGHT));
      else if (rc < 60) code = CODE_ESC;
      else if (rc < 68) code = CODE_CTRL;
      else if (rc < 75) code = 8'($urandom_range(CODE_MOD_LO, CODE_CTRL));
      else if (rc < 80) code = 8'($urandom_range(CODE_MOD_LO - 2, CODE_RIGHT + 2));
      else code = 8'($urandom);
      if (k >= n_ev) begin
        st = 8'($urandom);
        code = 8'($urandom);
      end
      bytes[4 + 2 * k] = st;
      bytes[5 + 2 * k] = code;
    end
    // some blocks get cut short by the next start
    stop_at = (r < 13) ? $urandom_range(1, BLOCK_BYTES - 1) : BLOCK_BYTES;
    for (int i = 0; i < stop_at; i++)
      put_word({bytes[i], i == 0, 1'($urandom_range(0, 1))}, 1'b0, '0);
    if (r >= 13 && r < 18)
      repeat ($urandom_range(1, 3))
        put_word({8'($urandom), 1'b0, 1'($urandom_range(0, 1))}, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_words.size() == 0) begin
        $display("%0t: unexpected word kind=%0d key=%02h type=%0d more=%0d last=%0d",
                 $time, out_data.result_kind, out_data.key_value, out_data.event_type,
                 out_data.more_pending, out_data.last_result);
        fail_count++;
      end else begin
        want = awaited_words.pop_front();
        if (out_data !== want) begin
          $display("%0t: mismatch expected kind=%0d key=%02h type=%0d more=%0d last=%0d",
                   $time, want.result_kind, want.key_value, want.event_type,
                   want.more_pending, want.last_result);
          $display("%0t:            actual kind=%0d key=%02h type=%0d more=%0d last=%0d",
                   $time, out_data.result_kind, out_data.key_value, out_data.event_type,
                   out_data.more_pending, out_data.last_result);
          fail_count++;
        end
        if (want.result_kind == RESULT_SUMMARY) summary_seen++;
        else key_seen++;
      end
    end
  end

  // receiver stalls
  initial begin
    int idle_n;
    int run;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      idle_n = gap_len();
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
      if (idle_n > 0) begin
        out_ready <= 1'b0;
        repeat (idle_n) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat (run) @(negedge clk);
    end
  end

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [4:0][7:0] regs_v;
    int goal;
    bit paused;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_ATTN;
    cfg_data = '0;
    steady = 1'b0;
    fail_count = 0;
    items_taken = 0;
    key_seen = 0;
    summary_seen = 0;
    pos_q = '0;
    depth_q = '0;
    count_q = '0;
    stopped_q = 1'b0;
    state_q = STATE_IDLE;
    ctrl_q = 1'b0;
    attn_r = 1'b0;
    up_r = 8'd1;
    down_r = 8'd2;
    left_r = 8'd3;
    right_r = 8'd4;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // first byte after reset carries no start flag but still opens a block
    steps.push_back(mk_row(8'hff, 1'b0, '0));
    steps.push_back(mk_row(8'h00, 1'b0, '0));
    steps.push_back(mk_row(8'hff, 1'b0, '0));
    steps.push_back(mk_row(8'hff, 1'b0, '0));           // count clamps
    steps.push_back(mk_row(8'h01, 1'b0, '0));
    steps.push_back(mk_row(CODE_CTRL, 1'b0, '0));       // ctrl down
    steps.push_back(mk_row(8'h02, 1'b0, '0));           // hold counts as press
    steps.push_back(mk_row(CHAR_LO_A, 1'b0, key_word(8'd1, EV_PRESS)));
    steps.push_back(mk_row(STATE_REL, 1'b0, '0));
    steps.push_back(mk_row(CHAR_UP_Z, 1'b0, key_word(8'd26, EV_RELEASE)));
    steps.push_back(mk_row(8'hff, 1'b0, '0));
    steps.push_back(mk_row(CODE_UP, 1'b0, key_word(8'd1, EV_SPECIAL_PRESS)));
    steps.push_back(mk_row(STATE_REL, 1'b0, '0));
    steps.push_back(mk_row(CODE_RIGHT, 1'b0, key_word(8'd4, EV_SPECIAL_RELEASE)));
    steps.push_back(mk_row(8'h01, 1'b0, '0));
    steps.push_back(mk_row(CODE_ESC, 1'b0, key_word(ESC_CHAR, EV_PRESS)));
    steps.push_back(mk_row(STATE_REL, 1'b0, '0));
    steps.push_back(mk_row(CODE_CTRL, 1'b0, '0));       // ctrl up
    steps.push_back(mk_row(8'h01, 1'b0, '0));
    steps.push_back(mk_row(CHAR_LO_Z, 1'b0, '0));       // key plus summary
    steps.push_back(mk_row(8'h00, 1'b0, '0));           // past the block: dropped
    steps.push_back(mk_row(8'h08, 1'b1, '0));
    steps.push_back(mk_row(8'h00, 1'b0, '0));
    steps.push_back(mk_row(8'h00, 1'b1, '0));           // restart mid-block
    steps.push_back(mk_row(8'h7f, 1'b0, '0));
    steps.push_back(mk_row(8'h80, 1'b0, '0));
    steps.push_back(mk_row(8'h02, 1'b0, '0));
    steps.push_back(mk_row(STATE_IDLE, 1'b0, '0));      // idle state stops parsing
    steps.push_back(mk_row(CHAR_LO_A, 1'b0, '0));
    foreach (steps[i]) put_word(steps[i].w, steps[i].typed, steps[i].want);

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: regs_v = {8'h00, 8'h00, 8'h00, 8'h00, 8'h01};
        1: regs_v = {8'hff, 8'hff, 8'hff, 8'hff, 8'hfe};
        default: for (int k = 0; k < 5; k++) regs_v[k] = 8'($urandom);
      endcase
      load_settings(regs_v);
      goal = items_taken + RAND_ITEMS / PHASES;
      paused = 1'b0;
      while (items_taken < goal) begin
        send_block();
        if (!paused && $urandom_range(0, 3) == 0) begin
          settle();
          paused = 1'b1;
        end
      end
    end
    settle();

    $display("Decoded %0d block bytes into %0d key words and %0d block summaries,",
             items_taken, key_seen, summary_seen);
    $display("across %0d register settings including all-zero and all-one keycodes.",
             PHASES + 1);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
